@@ src/wrdr_pkg.sv @@
// Shared types and constants for the weighted random draw core.
package wrdr_pkg;

  localparam int TOTAL_BITS      = 22;
  localparam int MODE_BITS       = 2;
  localparam int IDX_BITS        = 6;
  localparam int IN_W_BITS       = 16;
  localparam int IN_U_BITS       = 16;
  localparam int CFG_BITS        = 7;
  localparam int ENTRY_COUNT_RST = 64;
  localparam int S_DATA_BITS     = 40;
  localparam int M_DATA_BITS     = 32;

  // field offsets inside the input tdata word
  localparam int S_IDX_LSB  = 0;
  localparam int S_W_LSB    = S_IDX_LSB + IDX_BITS;
  localparam int S_FLAG_LSB = S_W_LSB + IN_W_BITS;
  localparam int S_U_LSB    = S_FLAG_LSB + 1;

  typedef enum logic [1:0] {
    MODE_LOAD       = 2'd0,
    MODE_SET_ACTIVE = 2'd1,
    MODE_DRAW       = 2'd2,
    MODE_NOP        = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_WR,
    ST_PREP,
    ST_WALK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic start;  // clear prefix sum
    logic issue;  // a table read was issued this cycle
    logic flush;  // drop everything in flight
  } scan_ctl_t;

  typedef struct packed {
    logic hit;
    logic busy;
  } scan_sts_t;

endpackage

@@ src/wrdr_ram.sv @@
// Entry table: one write port, one registered read port.
module wrdr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/wrdr_scan.sv @@
// Prefix-sum and threshold compare pipeline used by the draw walk.
module wrdr_scan #(
  parameter int WB = 16,
  parameter int RB = 16,
  parameter int AW = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wrdr_pkg::scan_ctl_t                 ctl_i,
  input  logic [AW-1:0]                       addr_i,
  input  logic [WB:0]                         rdata_i,
  input  logic [wrdr_pkg::TOTAL_BITS+RB-1:0]  lhs_i,
  output wrdr_pkg::scan_sts_t                 sts_o,
  output logic [AW-1:0]                       hit_idx_o,
  output logic [WB-1:0]                       hit_wdec_o
);

  import wrdr_pkg::*;

  localparam int PW   = TOTAL_BITS + 1;
  localparam int SUMW = ((PW > WB) ? PW : WB) + 1;
  localparam int MW   = PW + RB;
  localparam logic [PW-1:0] PMAX = {1'b1, {TOTAL_BITS{1'b0}}};

  logic          v0_q, v1_q, v2_q;
  logic [AW-1:0] i0_q, i1_q, i2_q;
  logic          a1_q, a2_q;
  logic [WB-1:0] w1_q, w2_q;
  logic [PW-1:0] p_q, p_d;
  logic [MW-1:0] pu_q;
  logic [SUMW-1:0] psum;
  logic          hit, kill;

  // stage 1: saturating prefix sum over every entry
  assign psum = SUMW'(p_q) + SUMW'(rdata_i[WB-1:0]);
  assign p_d  = (psum > SUMW'(PMAX)) ? PMAX : psum[PW-1:0];

  // stage 3: total*u < p*UMAX
  assign hit  = v2_q && a2_q && (MW'(lhs_i) < pu_q);
  assign kill = ctl_i.flush || hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      p_q  <= '0;
    end else begin
      v0_q <= ctl_i.issue && !kill;
      v1_q <= v0_q && !kill;
      v2_q <= v1_q && !kill;
      if (ctl_i.start) begin
        p_q <= '0;
      end else if (v0_q && !kill) begin
        p_q <= p_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i0_q <= addr_i;
    i1_q <= i0_q;
    a1_q <= rdata_i[WB];
    w1_q <= rdata_i[WB-1:0];
    i2_q <= i1_q;
    a2_q <= a1_q;
    w2_q <= w1_q;
    // stage 2: p*UMAX as shift minus p
    pu_q <= {p_q, {RB{1'b0}}} - MW'(p_q);
  end

  assign sts_o.hit  = hit;
  assign sts_o.busy = v0_q || v1_q || v2_q;
  assign hit_idx_o  = i2_q;
  assign hit_wdec_o = (w2_q != '0) ? (w2_q - WB'(1)) : '0;

endmodule

@@ src/weighted_random_draw_without_replacement_core.sv @@
// Top level: sequencer, registers and stream ports of the weighted draw core.
// Load and no-op words go from idle straight to the result state; set-active passes
// a table write state first. Draw: one table read per cycle walks min(entry_count,
// ENTRIES) entries through a 3-stage prefix/compare pipeline, then drains it; a hit ends the walk early.
// One word at a time: s_axis_tready_o is high only while the sequencer is idle.
// After reset a clear pass over all ENTRIES entries zeroes the table before the first
// word is taken; config writes are taken at any time. Control state resets.
module weighted_random_draw_without_replacement_core #(
  parameter int ENTRIES     = 64,
  parameter int WEIGHT_BITS = 16,
  parameter int RANDOM_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // config: entry_count
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wrdr_pkg::CFG_BITS-1:0]      cfg_data_i,
  // input words
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata: entry_index[5:0], weight[21:6], active_flag[22], random_value[38:23]
  input  logic [wrdr_pkg::S_DATA_BITS-1:0]   s_axis_tdata_i,
  // tuser: mode[1:0]
  input  logic [wrdr_pkg::MODE_BITS-1:0]     s_axis_tuser_i,
  // result words
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata: picked_index[5:0], total_left[27:6]
  output logic [wrdr_pkg::M_DATA_BITS-1:0]   m_axis_tdata_o,
  // tuser: picked[0]
  output logic                               m_axis_tuser_o
);

  import wrdr_pkg::*;

  localparam int AW  = $clog2(ENTRIES);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int IW  = (AW > IDX_BITS) ? AW : IDX_BITS;
  localparam int TB  = TOTAL_BITS;
  localparam int SW  = ((TB > WEIGHT_BITS) ? TB : WEIGHT_BITS) + 1;
  localparam int LW  = TB + RANDOM_BITS;
  localparam int PAD = M_DATA_BITS - IDX_BITS - TB;
  localparam logic [TB-1:0] TOTAL_MAX = {TB{1'b1}};

  state_e state_q, state_d;

  // control state
  logic [AW-1:0]       clr_q, clr_d;
  logic [CFG_BITS-1:0] ec_q;
  logic [TB-1:0]       total_q, total_d;
  logic [CW-1:0]       iss_q, iss_d;
  logic                m_valid_q, m_valid_d;

  // payload
  logic [CW-1:0]          n_q;
  logic [LW-1:0]          lhs_q;
  logic [AW-1:0]          addr_q;
  logic                   inrange_q;
  logic                   flag_q;
  logic [RANDOM_BITS-1:0] u_q;
  logic                   res_pick_q;
  logic [AW-1:0]          res_idx_q;
  logic                   out_pick_q;
  logic [M_DATA_BITS-1:0] out_data_q;

  // input word fields
  logic                   accept;
  mode_e                  in_mode;
  logic [IDX_BITS-1:0]    in_idx;
  logic [IW-1:0]          in_idx_w;
  logic [AW-1:0]          in_addr;
  logic                   in_range;
  logic [WEIGHT_BITS-1:0] in_w;
  logic [SW-1:0]          ld_sum;
  logic [CW-1:0]          walk_n;

  // table and scan
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [WEIGHT_BITS:0]   ram_wdata, ram_rdata;
  scan_ctl_t              scan_ctl;
  scan_sts_t              scan_sts;
  logic [AW-1:0]          hit_idx;
  logic [WEIGHT_BITS-1:0] hit_wdec;
  logic                   issue_left, walk_done, out_free;
  logic [IW-1:0]          res_idx_w;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign in_mode  = mode_e'(s_axis_tuser_i);
  assign in_idx   = s_axis_tdata_i[S_IDX_LSB +: IDX_BITS];
  assign in_idx_w = IW'(in_idx);
  assign in_addr  = in_idx_w[AW-1:0];
  assign in_range = 32'(in_idx) < 32'(ENTRIES);
  assign in_w     = WEIGHT_BITS'(s_axis_tdata_i[S_W_LSB +: IN_W_BITS]);
  assign ld_sum   = SW'(total_q) + SW'(in_w);
  assign walk_n   = (32'(ec_q) > 32'(ENTRIES)) ? CW'(ENTRIES) : CW'(ec_q);

  assign issue_left = iss_q < n_q;
  assign walk_done  = !issue_left && !scan_sts.busy;
  assign out_free   = !m_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (32'(clr_q) == 32'(ENTRIES - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_SET_ACTIVE: state_d = ST_SET_WR;
            MODE_DRAW:       state_d = ST_PREP;
            default:         state_d = ST_RESP;
          endcase
        end
      end
      ST_SET_WR: state_d = ST_RESP;
      ST_PREP:   state_d = ST_WALK;
      ST_WALK: begin
        if (scan_sts.hit || walk_done) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // table port, scan control and counters
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = '0;
    ram_raddr = iss_q[AW-1:0];
    scan_ctl  = '{start: 1'b0, issue: 1'b0, flush: 1'b1};
    clr_d     = clr_q;
    iss_d     = iss_q;
    total_d   = total_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
      end
      ST_IDLE: begin
        ram_raddr = in_addr;
        if (accept && in_mode == MODE_LOAD && in_range) begin
          ram_we    = 1'b1;
          ram_waddr = in_addr;
          ram_wdata = {1'b1, in_w};
          total_d   = (ld_sum > SW'(TOTAL_MAX)) ? TOTAL_MAX : ld_sum[TB-1:0];
        end
      end
      ST_SET_WR: begin
        ram_we    = inrange_q;
        ram_wdata = {flag_q, ram_rdata[WEIGHT_BITS-1:0]};
      end
      ST_PREP: begin
        scan_ctl.start = 1'b1;
        iss_d          = '0;
      end
      ST_WALK: begin
        scan_ctl.flush = 1'b0;
        scan_ctl.issue = issue_left && !scan_sts.hit;
        if (scan_ctl.issue) iss_d = iss_q + CW'(1);
        if (scan_sts.hit) begin
          // take the picked ticket back out of its entry
          ram_we    = 1'b1;
          ram_waddr = hit_idx;
          ram_wdata = {1'b1, hit_wdec};
        end
        if (scan_sts.hit || walk_done) begin
          total_d = (total_q != '0) ? (total_q - TB'(1)) : '0;
        end
      end
      ST_RESP: begin
        if (out_free) m_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      ec_q      <= CFG_BITS'(ENTRY_COUNT_RST);
      total_q   <= '0;
      iss_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      total_q   <= total_d;
      iss_q     <= iss_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ec_q <= cfg_data_i;
      end
    end
  end

  assign res_idx_w = IW'(res_idx_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q     <= in_addr;
      inrange_q  <= in_range;
      flag_q     <= s_axis_tdata_i[S_FLAG_LSB];
      u_q        <= RANDOM_BITS'(s_axis_tdata_i[S_U_LSB +: IN_U_BITS]);
      res_pick_q <= 1'b0;
      res_idx_q  <= '0;
    end
    if (state_q == ST_PREP) begin
      lhs_q <= LW'(total_q) * LW'(u_q);
      n_q   <= walk_n;
    end
    if (state_q == ST_WALK && scan_sts.hit) begin
      res_pick_q <= 1'b1;
      res_idx_q  <= hit_idx;
    end
    if (state_q == ST_RESP && out_free) begin
      out_pick_q <= res_pick_q;
      out_data_q <= {{PAD{1'b0}}, total_q, res_idx_w[IDX_BITS-1:0]};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_pick_q;

  wrdr_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (WEIGHT_BITS + 1)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  wrdr_scan #(
    .WB (WEIGHT_BITS),
    .RB (RANDOM_BITS),
    .AW (AW)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (scan_ctl),
    .addr_i     (ram_raddr),
    .rdata_i    (ram_rdata),
    .lhs_i      (lhs_q),
    .sts_o      (scan_sts),
    .hit_idx_o  (hit_idx),
    .hit_wdec_o (hit_wdec)
  );

`ifndef NO_ASSERTIONS
  a_hit_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_sts.hit |-> state_q == ST_WALK)
    else $error("scan hit outside walk");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> iss_q <= n_q)
    else $error("walk issued past entry count");

  a_no_pick_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> m_axis_tdata_o[IDX_BITS-1:0] == '0)
    else $error("index set without pick");

  a_resp_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && scan_sts.hit) |=> state_q == ST_RESP && res_pick_q)
    else $error("hit not carried to result");
`endif

endmodule

@@ tb/sv/tb_weighted_random_draw_without_replacement_core.sv @@
// Self-checking testbench of the weighted draw core: directed table, random phases, scoreboard.
module tb_weighted_random_draw_without_replacement_core;
  import wrdr_pkg::*;

  localparam int ENTRIES     = 64;
  localparam int DRAIN       = ENTRIES + 16;   // longest walk plus pipeline drain
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 65;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 13;
  localparam int MAX_REPORTS = 20;

  // one input word plus an optional typed-in expectation
  typedef struct packed {
    logic        typed;
    logic        t_picked;
    logic [5:0]  t_idx;
    logic [21:0] t_total;
    mode_e       mode;
    logic [5:0]  idx;
    logic [15:0] wgt;
    logic        flag;
    logic [15:0] u;
  } stim_word_t;

  typedef struct packed {
    logic        picked;
    logic [5:0]  idx;
    logic [21:0] total;
  } draw_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_BITS-1:0]    cfg_data_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [S_DATA_BITS-1:0] s_axis_tdata_i;
  logic [MODE_BITS-1:0]   s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [M_DATA_BITS-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;

  weighted_random_draw_without_replacement_core #(
    .ENTRIES    (ENTRIES),
    .WEIGHT_BITS(16),
    .RANDOM_BITS(16)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the table, the running total and entry_count
  // ---------------------------------------------------------------------------
  logic [15:0] weight_tbl [ENTRIES];
  logic        active_tbl [ENTRIES];
  logic [21:0] draw_sum;
  logic [6:0]  walk_len;

  draw_result_t awaited_results [$];
  stim_word_t   cur_word;
  int           err_cnt;
  int           words_seen, draws_seen, picks_seen, settings_seen;
  int           cyc;
  bit           calm;       // no idling on either side
  bit           hold_req;   // receiver goes quiet for a long stretch

  // Applies one word to the shadow state and returns the result it causes.
  function automatic draw_result_t apply_word(stim_word_t w);
    draw_result_t     r;
    longint unsigned  lhs, pre, acc;
    int               n;
    bit               found;
    r     = '0;
    found = 1'b0;
    case (w.mode)
      MODE_LOAD: begin
        weight_tbl[w.idx] = w.wgt;
        active_tbl[w.idx] = 1'b1;
        acc = longint'(draw_sum) + longint'(w.wgt);
        draw_sum = (acc > 64'h3F_FFFF) ? 22'h3F_FFFF : acc[21:0];
      end
      MODE_SET_ACTIVE: active_tbl[w.idx] = w.flag;
      MODE_DRAW: begin
        lhs = longint'(draw_sum) * longint'(w.u);
        pre = 0;
        n   = (walk_len > ENTRIES) ? ENTRIES : walk_len;
        for (int i = 0; i < n; i++) begin
          if (!found) begin
            pre = pre + weight_tbl[i];
            if (pre > 64'h40_0000) pre = 64'h40_0000;
            if (active_tbl[i] && lhs < pre * 64'd65535) begin
              found    = 1'b1;
              r.picked = 1'b1;
              r.idx    = 6'(i);
              if (weight_tbl[i] != 0) weight_tbl[i] = weight_tbl[i] - 1'b1;
            end
          end
        end
        if (draw_sum != 0) draw_sum = draw_sum - 1'b1;
      end
      default: ;  // unused mode leaves everything alone
    endcase
    r.total = draw_sum;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: results are checked against the oldest expectation, accepted
  // input words push a new one. A result never appears on the edge its word
  // is taken, so one block handles both sides.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : scoreboard
    draw_result_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.picked = m_axis_tuser_o;
        got.idx    = m_axis_tdata_o[5:0];
        got.total  = m_axis_tdata_o[27:6];
        if (got.picked) picks_seen++;
        if (awaited_results.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: unexpected result word picked=%0d idx=%0d total=%0d",
                     $time, got.picked, got.idx, got.total);
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS)
              $display({"%0t: mismatch exp picked=%0d idx=%0d total=%0d,",
                        " got picked=%0d idx=%0d total=%0d"},
                       $time, want.picked, want.idx, want.total,
                       got.picked, got.idx, got.total);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        want = apply_word(cur_word);
        if (cur_word.typed) begin
          want.picked = cur_word.t_picked;
          want.idx    = cur_word.t_idx;
          want.total  = cur_word.t_total;
        end
        awaited_results.push_back(want);
        words_seen++;
        if (cur_word.mode == MODE_DRAW) draws_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random backpressure, a calm phase, and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (calm) begin
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog
  initial begin
    cyc = 0;
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic stim_word_t row(mode_e m, logic [5:0] i, logic [15:0] w, logic f,
                                     logic [15:0] u, logic ty, logic pk, logic [5:0] pi,
                                     logic [21:0] tot);
    stim_word_t s;
    s.mode = m;  s.idx = i;  s.wgt = w;  s.flag = f;  s.u = u;
    s.typed = ty;  s.t_picked = pk;  s.t_idx = pi;  s.t_total = tot;
    return s;
  endfunction

  // Directed table; typed expectations only where they are obvious.
  function automatic stim_word_t directed_row(int n);
    case (n)
      // empty table, empty total
      0:  return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0, 6'd0,  22'd0);
      1:  return row(MODE_NOP,        6'd63, 16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 1'b0, 6'd0,  22'd0);
      2:  return row(MODE_LOAD,       6'd3,  16'h0002, 1'b0, 16'h1234, 1'b1, 1'b0, 6'd0,  22'd2);
      3:  return row(MODE_SET_ACTIVE, 6'd3,  16'hFFFF, 1'b0, 16'hFFFF, 1'b1, 1'b0, 6'd0,  22'd2);
      // nothing active: total still counts down to zero
      4:  return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'hFFFF, 1'b1, 1'b0, 6'd0,  22'd1);
      5:  return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'h0000, 1'b1, 1'b0, 6'd0,  22'd0);
      6:  return row(MODE_SET_ACTIVE, 6'd10, 16'hA5A5, 1'b1, 16'h5A5A, 1'b1, 1'b0, 6'd0,  22'd0);
      // zero total, entry 10 active with zero weight behind a nonzero prefix
      7:  return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'hFFFF, 1'b1, 1'b1, 6'd10, 22'd0);
      8:  return row(MODE_LOAD,       6'd0,  16'h0000, 1'b1, 16'h0000, 1'b1, 1'b0, 6'd0,  22'd0);
      9:  return row(MODE_LOAD,       6'd63, 16'hFFFF, 1'b0, 16'h0000, 1'b1, 1'b0, 6'd0,  22'd65535);
      10: return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'hFFFF, 1'b0, 1'b0, 6'd0,  22'd0);
      11: return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd0,  22'd0);
      12: return row(MODE_SET_ACTIVE, 6'd63, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd0,  22'd0);
      13: return row(MODE_SET_ACTIVE, 6'd10, 16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd0,  22'd0);
      14: return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd0,  22'd0);
      15: return row(MODE_SET_ACTIVE, 6'd63, 16'h0000, 1'b1, 16'h0000, 1'b0, 1'b0, 6'd0,  22'd0);
      16: return row(MODE_LOAD,       6'd20, 16'd100,  1'b0, 16'h0000, 1'b0, 1'b0, 6'd0,  22'd0);
      17: return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'h8000, 1'b0, 1'b0, 6'd0,  22'd0);
      18: return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'hFFFF, 1'b0, 1'b0, 6'd0,  22'd0);
      19: return row(MODE_LOAD,       6'd1,  16'h5555, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd0,  22'd0);
      20: return row(MODE_LOAD,       6'd2,  16'hAAAA, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd0,  22'd0);
      21: return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'h5555, 1'b0, 1'b0, 6'd0,  22'd0);
      22: return row(MODE_DRAW,       6'd0,  16'h0000, 1'b0, 16'hAAAA, 1'b0, 1'b0, 6'd0,  22'd0);
      23: return row(MODE_NOP,        6'd0,  16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0, 6'd0,  22'd0);
      default:
          return row(MODE_SET_ACTIVE, 6'd0,  16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 1'b0, 6'd0,  22'd0);
    endcase
  endfunction

  // Random word; most indices fall inside the walked span so draws can hit.
  function automatic stim_word_t rand_word(mode_e m, int span, bit heavy);
    stim_word_t s;
    s = '0;
    s.mode = m;
    if (span > 0 && $urandom_range(0, 99) < 80) s.idx = 6'($urandom_range(0, span - 1));
    else                                         s.idx = 6'($urandom_range(0, 63));
    if (heavy) s.wgt = 16'hFFFF;
    else begin
      case ($urandom_range(0, 9))
        0:       s.wgt = 16'h0000;
        1:       s.wgt = 16'hFFFF;
        8, 9:    s.wgt = 16'($urandom);
        default: s.wgt = 16'($urandom_range(1, 31));
      endcase
    end
    s.flag = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       s.u = 16'h0000;
      1:       s.u = 16'hFFFF;
      default: s.u = 16'($urandom);
    endcase
    return s;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input stim_word_t w);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    cur_word        <= w;
    s_axis_tdata_i  <= {1'b0, w.u, w.flag, w.wgt, w.idx};
    s_axis_tuser_i  <= w.mode;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic set_entry_count(input logic [6:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    walk_len = v;
    settings_seen++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drain all results, then give the walk time to settle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [6:0] ec_plan [PHASES];
    int         span, sent, nl, nd;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= MODE_NOP;
    cur_word        <= '0;
    rst_ni = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      weight_tbl[i] = '0;
      active_tbl[i] = 1'b0;
    end
    draw_sum      = '0;
    walk_len      = 7'(ENTRY_COUNT_RST);
    err_cnt       = 0;
    words_seen    = 0;
    draws_seen    = 0;
    picks_seen    = 0;
    settings_seen = 0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    // extremes 0 and 127 (walk clamps to ENTRIES), single entry, mid values
    ec_plan[0] = 7'd64;  ec_plan[1] = 7'd0;  ec_plan[2] = 7'd1;  ec_plan[3] = 7'd127;
    ec_plan[4] = 7'd2;   ec_plan[5] = 7'($urandom_range(3, 126));
    ec_plan[6] = 7'd40;  ec_plan[7] = 7'd64;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table at the reset walk length
    set_entry_count(7'd64);
    for (int n = 0; n < 25; n++) send_word(directed_row(n));
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      span = (ec_plan[ph] > ENTRIES) ? ENTRIES : ec_plan[ph];
      set_entry_count(ec_plan[ph]);
      calm = (ph == 2);
      if (ph == 4) hold_req = 1'b1;
      // last phase first piles max weights onto the total until it saturates
      if (ph == PHASES - 1)
        for (int k = 0; k < 70; k++) send_word(rand_word(MODE_LOAD, ENTRIES, 1'b1));
      sent = 0;
      while (sent < PHASE_WORDS) begin
        if ($urandom_range(0, 9) < 7) begin
          // refill a few entries, then a burst of draws
          nl = $urandom_range(1, 6);
          nd = $urandom_range(1, 10);
          repeat (nl) send_word(rand_word(MODE_LOAD, span, 1'b0));
          repeat (nd) send_word(rand_word(MODE_DRAW, span, 1'b0));
          sent += nl + nd;
        end else begin
          send_word(rand_word(mode_e'($urandom_range(0, 3)), span, 1'b0));
          sent++;
        end
      end
      wait_idle();
      calm = 1'b0;
    end

    $display("Covered %0d words, %0d draws with %0d picks, over %0d entry_count writes",
             words_seen, draws_seen, picks_seen, settings_seen);
    $display("Walk lengths included 0, 1, 2, 64 and 127; total saturation and long stall hit");
    if (err_cnt == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/wrdr_pkg.sv
src/wrdr_ram.sv
src/wrdr_scan.sv
src/weighted_random_draw_without_replacement_core.sv
tb/sv/tb_weighted_random_draw_without_replacement_core.sv
